[rtl/crc8_packet_framer_macros.svh]
// Assertion macros shared by the framer's checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CRC8_PACKET_FRAMER_MACROS_SVH
`define CRC8_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CFP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CFP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cfp_pkg.sv]
// Types, codes and the CRC-8 fold function for the packet framer.
// No dependencies; used by the interfaces, the top level and the checker.
package cfp_pkg;

    // Command codes of an input word.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Status codes of an output word.
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NO_PACKET  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY  = 2'd1;

    // Register reset values.
    localparam logic [7:0] SYNC_BYTE_RESET = 8'hF0;
    localparam logic [7:0] CRC_POLY_RESET  = 8'h07;

    // Top bit of the CRC register.
    localparam logic [7:0] CRC_MSB = 8'h80;

    // Most output words one input word can cause.
    localparam int unsigned MAX_WORDS = 4;

    typedef struct packed {
        logic       command;
        logic [7:0] msg_type;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_packet;
        logic       status;
    } word_t;

    // One byte folded into a CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc,
                                             input logic [7:0] m,
                                             input logic [7:0] poly);
        logic [7:0] v;
        v = crc ^ m;
        for (int i = 0; i < 8; i++)
        begin
            if ((v & CRC_MSB) != 8'h00)
            begin
                v = {v[6:0], 1'b0} ^ poly;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

[rtl/cfp_if.sv]
// Valid/ready channel interfaces of the packet framer: commands, output
// bytes and configuration writes. Depends on cfp_pkg.

// Command channel.
interface cfp_req_if;
    logic          valid;
    logic          ready;
    cfp_pkg::item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Output byte channel.
interface cfp_tx_if;
    logic          valid;
    logic          ready;
    cfp_pkg::word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// Configuration write channel.
interface cfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cfp_pkg::CFG_INDEX_W-1:0]  index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/crc8_packet_framer.sv]
// A command word passes through the holding stage and is loaded into the output word queue
// once the queue is empty or its last word leaves; the queue then offers its first word.
// Throughput: one output word per cycle while tx.ready is high; a start gives 3 or 4 output
// words, a payload byte 1 or 2, and a new command is taken whenever the holding stage is empty or its command loads.
// The output word register emits the queued words one a cycle unless tx.ready stalls it.
// Reset clears the CRC, the byte count, the open-packet flag and all valid flags, and
// returns the sync byte to 0xF0 and the polynomial to 0x07.
module crc8_packet_framer (
    input  logic      clk,
    input  logic      rst_n,
    cfp_req_if.sink   req,
    cfp_tx_if.source  tx,
    cfp_cfg_if.sink   cfg
);
    import cfp_pkg::*;

    // Configuration registers.
    logic [7:0] sync_reg;
    logic [7:0] poly_reg;

    // Command holding stage.
    logic       item_valid_reg;
    item_t      item_reg;
    logic [7:0] type_crc_reg;

    // Packet state.
    logic [7:0] crc_reg, crc_next;
    logic [7:0] left_reg, left_next;
    logic       open_reg, open_next;

    // Output word queue.
    word_t      words_reg [MAX_WORDS];
    word_t      words_next [MAX_WORDS];
    logic [2:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;

    logic       load;
    logic       pop;
    logic [7:0] fold_crc;
    logic [7:0] fold_byte;
    logic [7:0] new_crc;
    logic [7:0] left_dec;
    logic [2:0] load_count;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_BYTE_RESET;
            poly_reg <= CRC_POLY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SYNC_BYTE: sync_reg <= cfg.data;
                REG_CRC_POLY:  poly_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // The queue takes a new command when empty or when its last word leaves now.
    assign pop  = tx.valid && tx.ready;
    assign load = item_valid_reg &&
                  ((count_reg == 3'd0) || ((count_reg == 3'd1) && tx.ready));
    assign req.ready = !item_valid_reg || load;

    // Holding stage; the type byte is folded into a zero CRC on the way in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            item_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg     <= req.item;
            type_crc_reg <= crc8_fold(8'h00, req.item.msg_type, poly_reg);
        end
    end

    // The second CRC fold of a start is the length, onto the type CRC; a payload folds its data byte.
    assign fold_crc  = (item_reg.command == CMD_START) ? type_crc_reg : crc_reg;
    assign fold_byte = (item_reg.command == CMD_START) ? item_reg.payload_length
                                                       : item_reg.data_byte;
    assign new_crc   = crc8_fold(fold_crc, fold_byte, poly_reg);
    assign left_dec  = left_reg - 8'd1;

    // Build the output words and the next packet state for the held command.
    always_comb
    begin
        crc_next   = crc_reg;
        left_next  = left_reg;
        open_next  = open_reg;
        load_count = 3'd1;
        for (int i = 0; i < MAX_WORDS; i++)
        begin
            words_next[i] = words_reg[i];
        end

        if (item_reg.command == CMD_START)
        begin
            words_next[0] = '{sync_reg, 1'b0, STATUS_OK};
            words_next[1] = '{item_reg.msg_type, 1'b0, STATUS_OK};
            words_next[2] = '{item_reg.payload_length, 1'b0, STATUS_OK};
            words_next[3] = '{new_crc, 1'b1, STATUS_OK};
            crc_next      = new_crc;
            left_next     = item_reg.payload_length;
            open_next     = (item_reg.payload_length != 8'd0);
            load_count    = (item_reg.payload_length == 8'd0) ? 3'd4 : 3'd3;
        end
        else if (open_reg)
        begin
            words_next[0] = '{item_reg.data_byte, 1'b0, STATUS_OK};
            words_next[1] = '{new_crc, 1'b1, STATUS_OK};
            crc_next      = new_crc;
            left_next     = left_dec;
            open_next     = (left_dec != 8'd0);
            load_count    = (left_dec == 8'd0) ? 3'd2 : 3'd1;
        end
        else
        begin
            words_next[0] = '{8'h00, 1'b0, STATUS_NO_PACKET};
        end
    end

    // Queue pointers.
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = load_count;
            idx_next   = 2'd0;
        end
        else if (pop)
        begin
            count_next = count_reg - 3'd1;
            idx_next   = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= 8'h00;
            left_reg  <= 8'h00;
            open_reg  <= 1'b0;
            count_reg <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (load)
            begin
                crc_reg  <= crc_next;
                left_reg <= left_next;
                open_reg <= open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_WORDS; i++)
            begin
                words_reg[i] <= words_next[i];
            end
        end
    end

    // Output word.
    assign tx.valid = (count_reg != 3'd0);
    assign tx.word  = words_reg[idx_reg];

endmodule

[rtl/cfp_checker.sv]
// Port-level checker for the packet framer and its bind statement.
// Depends on cfp_pkg and crc8_packet_framer_macros.svh.
`include "crc8_packet_framer_macros.svh"

module cfp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  tx_valid,
    input logic                  tx_ready,
    input cfp_pkg::word_t        tx_word
);
    import cfp_pkg::*;

    // A stalled word stays offered.
    `CFP_ASSERT_NEXT(a_tx_hold, clk, rst_n, tx_valid && !tx_ready, tx_valid, "tx word withdrawn")
    // A stalled word keeps its value.
    `CFP_ASSERT_NEXT(a_tx_stable, clk, rst_n, tx_valid && !tx_ready, $stable(tx_word), "tx word changed")
    // The closing CRC is never an error word.
    `CFP_ASSERT_IMPL(a_last_ok, clk, rst_n, tx_valid && tx_word.last_of_packet, tx_word.status == STATUS_OK, "error word flagged last")
    // An error word carries a zero byte.
    `CFP_ASSERT_IMPL(a_err_zero, clk, rst_n, tx_valid && (tx_word.status == STATUS_NO_PACKET), tx_word.out_byte == 8'h00, "error word with data")

endmodule

bind crc8_packet_framer cfp_checker u_cfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_word  (tx.word)
);
